/* hw/rtl/spq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority ready queue package
// Shared constants, payload types, control types and the controller states.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int PRIORITY_BITS       = 8;
   localparam int ID_BITS             = 8;
   localparam int COUNT_BITS          = 5;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_REMOVE  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]               opcode;
      logic [ID_BITS-1:0]       item_id;
      logic [PRIORITY_BITS-1:0] priority_req;
   } spq_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [ID_BITS-1:0]       out_id;
      logic [PRIORITY_BITS-1:0] out_priority;
      logic [COUNT_BITS-1:0]    entry_count;
   } spq_rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0]       id;
      logic [PRIORITY_BITS-1:0] prio;
   } spq_entry_type;

   typedef struct packed {
      logic load;
      logic enq_step;
      logic enq_place;
      logic del_step;
      logic finish;
   } spq_cmd_type;

   typedef struct packed {
      logic [1:0] new_op;
      logic       empty;
      logic       full;
      logic       enq_done;
      logic       del_last;
   } spq_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ,
      ST_PLACE,
      ST_DEL,
      ST_FINISH
   } spq_state_type;

endpackage
`default_nettype wire

/* hw/rtl/spq_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority ready queue controller
// Sequences one request at a time through the slot walk and the result stage.
// ----------------------------------------------------------------------------
module spq_ctrl
   import spq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire spq_stat_type stat,
   output spq_cmd_type       cmd
);

   spq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (stat.new_op)
                  OP_ENQUEUE: begin
                     if (stat.full) begin
                        state_in = ST_FINISH;
                     end else if (stat.empty) begin
                        state_in = ST_PLACE;
                     end else begin
                        state_in = ST_ENQ;
                     end
                  end
                  OP_DEQUEUE, OP_REMOVE: begin
                     state_in = stat.empty ? ST_FINISH : ST_DEL;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_ENQ: begin
            if (stat.enq_done) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            state_in = ST_FINISH;
         end
         ST_DEL: begin
            if (stat.del_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_ENQ: begin
            cmd.enq_step = 1'b1;
         end
         ST_PLACE: begin
            cmd.enq_place = 1'b1;
         end
         ST_DEL: begin
            cmd.del_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A finished result waits in place while the output register is still full.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !rsp_free) |=> (state_ff == ST_FINISH && rsp_valid_ff))
      else $error("Result stage left while the output register was occupied.");

   // An accepted request keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready)
      else $error("Request taken while the previous one was still in progress.");

   // A result is only loaded when the output register can take it.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("Result overwritten before it was taken.");

endmodule
`default_nettype wire

/* hw/rtl/spq_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority ready queue datapath
// Slot memory, entry count, walk pointer, result and output registers.
// ----------------------------------------------------------------------------
module spq_datapath
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire spq_req_type req_data,
   output spq_rsp_type      rsp_data,
   input  wire spq_cmd_type cmd,
   output spq_stat_type     stat
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   spq_entry_type            mem [QUEUE_DEPTH];
   spq_entry_type            rd_data_ff;
   spq_req_type              req_ff;
   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            ptr_ff, ptr_in;
   logic                     found_ff, found_in;
   logic [1:0]               res_status_ff, res_status_in;
   logic [ID_BITS-1:0]       res_id_ff, res_id_in;
   logic [PRIORITY_BITS-1:0] res_prio_ff, res_prio_in;
   spq_rsp_type              rsp_ff;
   logic [CW-1:0]            rd_addr, wr_addr;
   spq_entry_type            wr_data;
   logic                     wr_en;
   logic                     enq_stop, del_match, del_last;
   logic [CW+COUNT_BITS-1:0] count_ext;

   assign enq_stop  = rd_data_ff.prio >= req_ff.priority_req;
   assign del_match = (req_ff.opcode == OP_DEQUEUE && ptr_ff == '0) ||
                      (req_ff.opcode == OP_REMOVE && rd_data_ff.id == req_ff.item_id);
   assign del_last  = ptr_ff == CW'(count_ff - 1'b1);
   assign count_ext = {{COUNT_BITS{1'b0}}, count_ff};

   assign stat.new_op   = req_data.opcode;
   assign stat.empty    = count_ff == '0;
   assign stat.full     = count_ff == CW'(QUEUE_DEPTH);
   assign stat.enq_done = enq_stop || ptr_ff == CW'(1);
   assign stat.del_last = del_last;

   always_comb begin
      rd_addr = '0;
      if (cmd.load) begin
         if (req_data.opcode == OP_ENQUEUE && count_ff != '0) begin
            rd_addr = CW'(count_ff - 1'b1);
         end
      end else if (cmd.enq_step) begin
         if (!enq_stop && ptr_ff >= CW'(2)) begin
            rd_addr = CW'(ptr_ff - 2'd2);
         end
      end else if (cmd.del_step) begin
         if (!del_last) begin
            rd_addr = CW'(ptr_ff + 1'b1);
         end
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = rd_data_ff;
      if (cmd.enq_step && !enq_stop) begin
         wr_en = 1'b1;
      end else if (cmd.enq_place) begin
         wr_en   = 1'b1;
         wr_data = '{id: req_ff.item_id, prio: req_ff.priority_req};
      end else if (cmd.del_step && found_ff) begin
         wr_en   = 1'b1;
         wr_addr = CW'(ptr_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr[AW-1:0]];
      if (wr_en) begin
         mem[wr_addr[AW-1:0]] <= wr_data;
      end
   end

   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_prio_in   = res_prio_ff;
      if (cmd.load) begin
         found_in    = 1'b0;
         res_id_in   = '0;
         res_prio_in = '0;
         ptr_in      = (req_data.opcode == OP_ENQUEUE) ? count_ff : '0;
         case (req_data.opcode)
            OP_ENQUEUE: begin
               res_status_in = stat.full ? STATUS_FULL : STATUS_OK;
            end
            OP_DEQUEUE: begin
               res_status_in = stat.empty ? STATUS_EMPTY : STATUS_OK;
            end
            OP_REMOVE: begin
               res_status_in = STATUS_NOT_FOUND;
            end
            default: begin
               res_status_in = STATUS_OK;
            end
         endcase
      end else if (cmd.enq_step) begin
         if (!enq_stop) begin
            ptr_in = CW'(ptr_ff - 1'b1);
         end
      end else if (cmd.enq_place) begin
         count_in      = CW'(count_ff + 1'b1);
         res_status_in = STATUS_OK;
         res_id_in     = req_ff.item_id;
         res_prio_in   = req_ff.priority_req;
      end else if (cmd.del_step) begin
         ptr_in = CW'(ptr_ff + 1'b1);
         if (!found_ff && del_match) begin
            found_in      = 1'b1;
            res_status_in = STATUS_OK;
            res_id_in     = rd_data_ff.id;
            res_prio_in   = rd_data_ff.prio;
         end
         if (del_last && (found_ff || del_match)) begin
            count_in = CW'(count_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         found_ff <= found_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_prio_ff   <= res_prio_in;
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.finish) begin
         rsp_ff.status       <= res_status_ff;
         rsp_ff.out_id       <= res_id_ff;
         rsp_ff.out_priority <= res_prio_ff;
         rsp_ff.entry_count  <= count_ext[COUNT_BITS-1:0];
      end
   end

   assign rsp_data = rsp_ff;

   // The entry count never passes the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("Entry count exceeds the queue depth.");

   // Placing a new entry grows the queue by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      cmd.enq_place |=> count_ff == CW'($past(count_ff) + 1'b1))
      else $error("Enqueue did not grow the count by one.");

   // Slot writes stay within the occupied range plus the slot being filled.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr <= count_ff && wr_addr < CW'(QUEUE_DEPTH)))
      else $error("Slot write outside the occupied range.");

endmodule
`default_nettype wire

/* hw/rtl/stable_priority_ready_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority ready queue
// Process ids kept in non-increasing priority order with equal priorities in
// arrival order; enqueue, dequeue of the head and removal of a given id.
// ----------------------------------------------------------------------------
// Operation: a request is accepted, walks the slot memory one entry per cycle,
// and its result is registered in the output register once the walk ends.
// Flow: one request at a time; the walk over the single-read, single-write
// slot memory sets the rate, and the next request waits for the result stage.
// A result that waits on rsp_ready holds the next request back by that wait.
// Reset clears the entry count and handshake state; slots are not cleared.
module stable_priority_ready_queue
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire spq_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output spq_rsp_type      rsp_data
);

   spq_cmd_type  cmd;
   spq_stat_type stat;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   spq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .cmd      (cmd),
      .stat     (stat)
   );

endmodule
`default_nettype wire

/* bench/stable_priority_ready_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stable priority ready queue testbench
// Drives enqueue, dequeue and remove requests through the valid/ready ports,
// keeps its own ordered copy of the queue to predict every response, and
// compares each response field by field. It covers empty, full, absent and
// duplicate ids, and ties in priority, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module stable_priority_ready_queue_tb;
   import spq_pkg::*;

   localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int ITEMS_PER_PHASE = 350;
   localparam int SEGMENT_ITEMS = 40;
   localparam int TAIL_CYCLES = DEPTH + 8;
   localparam int MAX_REPORTS = 10;

   class spq_scoreboard;
      logic [ID_BITS-1:0]       slot_id [DEPTH];
      logic [PRIORITY_BITS-1:0] slot_prio [DEPTH];
      int                       count;
      spq_rsp_type              expected_rsps[$];
      int                       failures;

      function new();
         count = 0;
         failures = 0;
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      function void drop_slot(input int pos);
         int i;
         for (i = pos; i + 1 < count; i++) begin
            slot_id[i] = slot_id[i + 1];
            slot_prio[i] = slot_prio[i + 1];
         end
         count--;
      endfunction

      function void note_request(input spq_req_type r);
         spq_rsp_type e;
         int          pos;
         int          i;
         e = '0;
         pos = -1;
         case (r.opcode)
            OP_ENQUEUE: begin
               if (count >= DEPTH) begin
                  e.status = STATUS_FULL;
               end else begin
                  pos = 0;
                  while (pos < count && slot_prio[pos] >= r.priority_req) pos++;
                  for (i = count; i > pos; i--) begin
                     slot_id[i] = slot_id[i - 1];
                     slot_prio[i] = slot_prio[i - 1];
                  end
                  slot_id[pos] = r.item_id;
                  slot_prio[pos] = r.priority_req;
                  count++;
                  e.out_id = r.item_id;
                  e.out_priority = r.priority_req;
               end
            end
            OP_DEQUEUE: begin
               if (count == 0) begin
                  e.status = STATUS_EMPTY;
               end else begin
                  e.out_id = slot_id[0];
                  e.out_priority = slot_prio[0];
                  drop_slot(0);
               end
            end
            OP_REMOVE: begin
               for (i = 0; i < count && pos < 0; i++) begin
                  if (slot_id[i] == r.item_id) pos = i;
               end
               if (pos < 0) begin
                  e.status = STATUS_NOT_FOUND;
               end else begin
                  e.out_id = slot_id[pos];
                  e.out_priority = slot_prio[pos];
                  drop_slot(pos);
               end
            end
            default: begin
            end
         endcase
         e.entry_count = COUNT_BITS'(count);
         expected_rsps.push_back(e);
      endfunction

      function void check_response(input spq_rsp_type got);
         spq_rsp_type e;
         if (expected_rsps.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected response %h", $realtime, got);
            return;
         end
         e = expected_rsps.pop_front();
         if (got.status !== e.status || got.out_id !== e.out_id ||
             got.out_priority !== e.out_priority ||
             got.entry_count !== e.entry_count) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display({"%0t: mismatch status %0d/%0d id %h/%h priority %h/%h ",
                         "count %0d/%0d (expected/actual)"}, $realtime,
                        e.status, got.status, e.out_id, got.out_id,
                        e.out_priority, got.out_priority,
                        e.entry_count, got.entry_count);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   spq_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   spq_rsp_type rsp_data;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   spq_scoreboard sb;

   stable_priority_ready_queue #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   task automatic send_request(input logic [1:0] op, input logic [7:0] id,
                               input logic [7:0] prio);
      spq_req_type r;
      r.opcode = op;
      r.item_id = id;
      r.priority_req = prio;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
   endtask

   task automatic drain_queue();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() > 0);
   endtask

   task automatic send_random(input bit fill_bias);
      int          pick;
      logic [1:0]  op;
      logic [7:0]  id;
      logic [7:0]  prio;
      pick = $urandom_range(99);
      if (fill_bias)
         op = pick < 75 ? OP_ENQUEUE : pick < 88 ? OP_DEQUEUE :
              pick < 98 ? OP_REMOVE : OP_UNUSED;
      else
         op = pick < 25 ? OP_ENQUEUE : pick < 60 ? OP_DEQUEUE :
              pick < 97 ? OP_REMOVE : OP_UNUSED;
      pick = $urandom_range(99);
      if (op == OP_REMOVE && sb.count > 0 && pick < 60)
         id = sb.slot_id[$urandom_range(sb.count - 1)];
      else if (pick < 80)
         id = 8'($urandom_range(15));
      else
         id = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 10)
         prio = 8'h00;
      else if (pick < 20)
         prio = 8'hff;
      else if (pick < 35 && sb.count > 0)
         prio = sb.slot_prio[$urandom_range(sb.count - 1)];
      else if (pick < 45)
         prio = 8'($urandom_range(4));
      else
         prio = 8'($urandom_range(255));
      send_request(op, id, prio);
   endtask

   initial begin
      #5_000_000;
      $display("stable_priority_ready_queue_tb NOT OK");
      $finish;
   end

   initial begin
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int phase;
      int n;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_DEQUEUE, 8'h00, 8'h00);
      send_request(OP_REMOVE, 8'h00, 8'h00);
      send_request(OP_UNUSED, 8'hff, 8'hff);
      send_request(OP_ENQUEUE, 8'h00, 8'h00);
      send_request(OP_ENQUEUE, 8'hff, 8'hff);
      send_request(OP_ENQUEUE, 8'h5a, 8'hff);
      send_request(OP_ENQUEUE, 8'ha5, 8'h80);
      send_request(OP_ENQUEUE, 8'h5a, 8'h80);
      send_request(OP_REMOVE, 8'h33, 8'hff);
      send_request(OP_REMOVE, 8'h5a, 8'h00);
      send_request(OP_UNUSED, 8'h00, 8'h00);
      send_request(OP_DEQUEUE, 8'hff, 8'hff);
      send_request(OP_REMOVE, 8'h00, 8'h00);
      send_request(OP_DEQUEUE, 8'h00, 8'h00);
      send_request(OP_DEQUEUE, 8'h00, 8'h00);
      send_request(OP_DEQUEUE, 8'h00, 8'h00);
      for (n = 0; n < DEPTH + 1; n++)
         send_request(OP_ENQUEUE, 8'(n * 17), 8'(n % 3));
      for (n = 0; n < 4; n++)
         send_request(OP_DEQUEUE, 8'h00, 8'h00);

      for (phase = 0; phase < 4; phase++) begin
         drain_queue();
         send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 64 : 21) : 0;
         recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 64 : 21) : 0;
         for (n = 0; n < ITEMS_PER_PHASE; n++)
            send_random(((n / SEGMENT_ITEMS) % 2) == 0);
      end

      drain_queue();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("stable_priority_ready_queue_tb OK");
      else
         $display("stable_priority_ready_queue_tb NOT OK");
      $finish;
   end
endmodule
